### src/fdx_pkg.sv
// flanger delay effect: shared constants, register codes, multiply unit control types
// and the sine quarter-wave generator function
// no dependencies
`default_nettype none

package fdx_pkg;

	// default sizes for the top level parameters
	localparam int MAX_DELAY_DEF       = 1024;
	localparam int SAMPLE_WIDTH_DEF    = 16;
	localparam int SINE_TABLE_BITS_DEF = 10;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_STEP = 4'd0,
		REG_DEPTH      = 4'd1,
		REG_FB_GAIN    = 4'd2,
		REG_MIX        = 4'd3
	} fdx_reg_t;

	// register reset values
	localparam logic [30:0]        PHASE_STEP_RST = 31'd24347;
	localparam logic [9:0]         DEPTH_RST      = 10'd8;
	localparam logic signed [15:0] FB_GAIN_RST    = 16'sd9830;
	localparam logic [15:0]        MIX_RST        = 16'd16384;

	// gain and mix limits
	localparam logic signed [15:0] FB_LIMIT = 16'sd31129;
	localparam logic [15:0]        MIX_ONE  = 16'd32768;

	// multiplier operand width of the bit-serial unit (signed)
	localparam int MB_W = 17;

	typedef struct packed {
		logic start;
		logic keep;
	} fdx_mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} fdx_mac_sts_t;

	// one quarter-wave sine point, u in 0..2^(stb-2), Q15 output clamped to 0..32767
	function automatic logic [14:0] sine_quarter(input int u, input int stb);
		longint x;
		longint x2;
		longint x3;
		longint x5;
		longint s;
		x  = longint'(u) <<< (17 - stb);
		x2 = (x * x + 64'sd16384) >>> 15;
		x3 = (x2 * x + 64'sd16384) >>> 15;
		x5 = (x3 * x2 + 64'sd16384) >>> 15;
		s  = (64'sd51472 * x - 64'sd21167 * x3 + 64'sd2611 * x5 + 64'sd16384) >>> 15;
		if (s < 0) s = 0;
		if (s > 32767) s = 32767;
		return 15'(s);
	endfunction

endpackage

`default_nettype wire

### src/fdx_if.sv
// flanger delay effect: channel interfaces for samples in, samples out and config writes
// depends on fdx_pkg
`default_nettype none

interface fdx_in_if #(parameter int W = fdx_pkg::SAMPLE_WIDTH_DEF);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface fdx_out_if #(parameter int W = fdx_pkg::SAMPLE_WIDTH_DEF);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

interface fdx_cfg_if;
	import fdx_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/fdx_ram.sv
// flanger delay effect: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module fdx_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### src/fdx_smac.sv
// flanger delay effect: bit-serial multiply-accumulate, one multiplier bit per cycle
// signed multiplicand times signed MB_W-bit multiplier; depends on fdx_pkg
`default_nettype none

module fdx_smac #(
	parameter int A_W   = 17,
	parameter int ACC_W = 35
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fdx_pkg::fdx_mac_ctl_t    ctl,
	input  logic signed [A_W-1:0]    mcand,
	input  logic signed [fdx_pkg::MB_W-1:0] mplier,
	output fdx_pkg::fdx_mac_sts_t    sts,
	output logic signed [ACC_W-1:0]  acc
);
	import fdx_pkg::*;

	localparam int CNT_W = $clog2(MB_W + 1);

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] mcand_q;
	logic [MB_W-1:0]         mplier_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    done_q;
	logic                    last_bit;

	// the sign bit of the multiplier carries negative weight
	assign last_bit = (cnt_q == CNT_W'(1));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q <= CNT_W'(MB_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (last_bit) done_q <= 1'b1;
			end
		end
	end

	// shift and add datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mcand_q  <= ACC_W'(mcand);
			mplier_q <= mplier;
			if (!ctl.keep) acc_q <= '0;
		end else if (cnt_q != '0) begin
			if (mplier_q[0]) begin
				if (last_bit) acc_q <= acc_q - mcand_q;
				else acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign acc      = acc_q;

endmodule

`default_nettype wire

### src/flanger_delay_fx.sv
// flanger delay effect top level: sine LFO, delay memory with feedback, dry/wet mix
// depends on fdx_pkg, fdx_if, fdx_ram and fdx_smac
//
//   channel  dir  payload             transfer when
//   din      in   sample_in           din.valid && din.ready
//   dout     out  sample_out          dout.valid && dout.ready
//   cfg      in   index, data         cfg.valid && cfg.ready (always ready)
//
// from transfer in to result valid: a table lookup step, four products of 17-bit
// operands (LFO times depth, feedback, dry, wet) on the shared serial multiply unit,
// one multiplier bit per cycle, and one output step.
// din is ready only while no sample is in work; a finished result waits in the
// output register and the next sample is taken while it waits.
// no clearing pass after reset: a fill count marks delay memory words never written.
`default_nettype none

module flanger_delay_fx #(
	parameter int MAX_DELAY       = fdx_pkg::MAX_DELAY_DEF,
	parameter int SAMPLE_WIDTH    = fdx_pkg::SAMPLE_WIDTH_DEF,
	parameter int SINE_TABLE_BITS = fdx_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fdx_in_if.sink     din,
	fdx_out_if.source  dout,
	fdx_cfg_if.sink    cfg
);
	import fdx_pkg::*;

	localparam int SW     = SAMPLE_WIDTH;
	localparam int AW     = ((SW > 16) ? SW : 16) + 1;
	localparam int ACC_W  = AW + MB_W + 1;
	localparam int PTR_W  = $clog2(MAX_DELAY);
	localparam int FILL_W = $clog2(MAX_DELAY + 1);
	localparam int STB    = SINE_TABLE_BITS;
	localparam int QSIZE  = 1 << (STB - 2);
	localparam int U_W    = STB - 1;

	localparam logic signed [ACC_W-1:0] RND_C = ACC_W'(16384);
	localparam logic signed [ACC_W-1:0] S_HI  = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] S_LO  = -S_HI - ACC_W'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROM,
		S_DLY,
		S_FB,
		S_M3,
		S_M4,
		S_OUT
	} state_t;

	// configuration registers
	logic [30:0]        phase_step_q;
	logic [9:0]         depth_q;
	logic signed [15:0] fb_gain_q;
	logic [15:0]        mix_q;

	// sequencer and datapath state
	state_t                  state_q;
	fdx_mac_ctl_t            mac_ctl_q;
	fdx_mac_sts_t            mac_sts;
	logic signed [AW-1:0]    op_a_q;
	logic signed [MB_W-1:0]  op_b_q;
	logic signed [ACC_W-1:0] acc;
	logic signed [SW-1:0]    x_q;
	logic [14:0]             s_q;
	logic                    quad_hi_q;
	logic [31:0]             lfo_phase_q;
	logic [PTR_W-1:0]        wp_q;
	logic [FILL_W-1:0]       fill_q;
	logic signed [SW-1:0]    last_wet_q;
	logic signed [SW-1:0]    wet_q;
	logic [PTR_W-1:0]        rd_addr_q;
	logic                    rd_re_q;
	logic                    rd_ok_q;
	logic                    ram_we_q;
	logic [PTR_W-1:0]        ram_waddr_q;
	logic [SW-1:0]           ram_wdata_q;
	logic [SW-1:0]           ram_rdata;
	logic signed [SW-1:0]    out_q;
	logic                    out_valid_q;

	// combinational helpers
	logic [14:0]             sine_lut [QSIZE+1];
	logic [STB-1:0]          idx;
	logic [U_W-1:0]          u_idx;
	logic signed [15:0]      gain_c;
	logic [15:0]             mix_c;
	logic [16:0]             lfo_sum;
	logic [14:0]             lfo01;
	logic [9:0]              dly_raw;
	logic [31:0]             dly_wide;
	logic [PTR_W-1:0]        dly;
	logic [PTR_W:0]          rd_diff;
	logic [PTR_W-1:0]        rd_addr;
	logic signed [SW-1:0]    wet_v;
	logic signed [SW-1:0]    fed;
	logic signed [SW-1:0]    y;
	logic                    out_load;

	function automatic logic signed [ACC_W-1:0] rnd15(input logic signed [ACC_W-1:0] v);
		return (v + RND_C) >>> 15;
	endfunction

	function automatic logic signed [SW-1:0] sat_s(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > S_HI) r = S_HI;
		if (v < S_LO) r = S_LO;
		return SW'(r);
	endfunction

	// quarter-wave sine table, worked out at elaboration
	for (genvar g = 0; g <= QSIZE; g++) begin : g_sine
		assign sine_lut[g] = sine_quarter(g, STB);
	end

	// table address from the phase accumulator, mirrored in odd quadrants
	assign idx   = lfo_phase_q[31 -: STB];
	assign u_idx = idx[STB-2] ? (U_W'(QSIZE) - U_W'(idx[STB-3:0])) : U_W'(idx[STB-3:0]);

	// clamped gain and mix
	always_comb begin
		gain_c = fb_gain_q;
		if (fb_gain_q > FB_LIMIT) gain_c = FB_LIMIT;
		if (fb_gain_q < -FB_LIMIT) gain_c = -FB_LIMIT;
		mix_c = (mix_q > MIX_ONE) ? MIX_ONE : mix_q;
	end

	// LFO mapped to 0..1 in Q15
	assign lfo_sum = quad_hi_q ? (17'd32768 - 17'(s_q)) : (17'd32768 + 17'(s_q));
	assign lfo01   = lfo_sum[15:1];

	// delay from LFO times depth, held to 1..MAX_DELAY-1, and read address
	always_comb begin
		dly_raw = acc[24:15];
		if (32'(dly_raw) > 32'(MAX_DELAY - 1)) dly_wide = 32'(MAX_DELAY - 1);
		else if (dly_raw == '0) dly_wide = 32'd1;
		else dly_wide = 32'(dly_raw);
		dly     = PTR_W'(dly_wide);
		rd_diff = {1'b0, wp_q} - {1'b0, dly};
		if (rd_diff[PTR_W]) rd_addr = PTR_W'(rd_diff + (PTR_W + 1)'(MAX_DELAY));
		else rd_addr = rd_diff[PTR_W-1:0];
	end

	// wet sample, zero for words never written
	assign wet_v = rd_ok_q ? $signed(ram_rdata) : '0;

	// feedback write value and final mix
	assign fed = sat_s(rnd15(acc) + ACC_W'(x_q));
	assign y   = sat_s(rnd15(acc));

	assign out_load = (state_q == S_OUT) && (!out_valid_q || dout.ready);

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_STEP_RST;
			depth_q      <= DEPTH_RST;
			fb_gain_q    <= FB_GAIN_RST;
			mix_q        <= MIX_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PHASE_STEP: phase_step_q <= cfg.data[30:0];
				REG_DEPTH:      depth_q      <= cfg.data[9:0];
				REG_FB_GAIN:    fb_gain_q    <= $signed(cfg.data[15:0]);
				REG_MIX:        mix_q        <= cfg.data[15:0];
				default:        ;
			endcase
		end
	end

	// sample sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mac_ctl_q   <= '0;
			rd_re_q     <= 1'b0;
			ram_we_q    <= 1'b0;
			out_valid_q <= 1'b0;
			wp_q        <= '0;
			fill_q      <= '0;
			lfo_phase_q <= '0;
			last_wet_q  <= '0;
		end else begin
			mac_ctl_q <= '0;
			rd_re_q   <= 1'b0;
			ram_we_q  <= 1'b0;
			if (out_valid_q && dout.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (din.valid) begin
						x_q       <= din.sample_in;
						s_q       <= sine_lut[u_idx];
						quad_hi_q <= idx[STB-1];
						state_q   <= S_ROM;
					end
				end
				S_ROM: begin
					op_a_q          <= AW'($signed({1'b0, lfo01}));
					op_b_q          <= MB_W'($signed({1'b0, depth_q}));
					mac_ctl_q.start <= 1'b1;
					state_q         <= S_DLY;
				end
				S_DLY: begin
					if (mac_sts.done) begin
						rd_addr_q       <= rd_addr;
						rd_re_q         <= 1'b1;
						rd_ok_q         <= (32'(dly) <= 32'(fill_q));
						op_a_q          <= AW'(last_wet_q);
						op_b_q          <= MB_W'(gain_c);
						mac_ctl_q.start <= 1'b1;
						state_q         <= S_FB;
					end
				end
				S_FB: begin
					if (mac_sts.done) begin
						ram_we_q    <= 1'b1;
						ram_waddr_q <= wp_q;
						ram_wdata_q <= fed;
						wp_q        <= (wp_q == PTR_W'(MAX_DELAY - 1)) ? '0 : wp_q + 1'b1;
						if (fill_q != FILL_W'(MAX_DELAY)) fill_q <= fill_q + 1'b1;
						last_wet_q      <= wet_v;
						wet_q           <= wet_v;
						op_a_q          <= AW'(x_q);
						op_b_q          <= MB_W'(MIX_ONE - mix_c);
						mac_ctl_q.start <= 1'b1;
						state_q         <= S_M3;
					end
				end
				S_M3: begin
					if (mac_sts.done) begin
						op_a_q          <= AW'(wet_q);
						op_b_q          <= MB_W'(mix_c);
						mac_ctl_q.start <= 1'b1;
						mac_ctl_q.keep  <= 1'b1;
						state_q         <= S_M4;
					end
				end
				S_M4: begin
					if (mac_sts.done) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_q       <= y;
						out_valid_q <= 1'b1;
						lfo_phase_q <= lfo_phase_q + 32'(phase_step_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// shared serial multiplier
	fdx_smac #(
		.A_W   (AW),
		.ACC_W (ACC_W)
	) u_smac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl_q),
		.mcand  (op_a_q),
		.mplier (op_b_q),
		.sts    (mac_sts),
		.acc    (acc)
	);

	// delay memory
	fdx_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_DELAY)
	) u_delay_mem (
		.clk   (clk),
		.we    (ram_we_q),
		.waddr (ram_waddr_q),
		.wdata (ram_wdata_q),
		.re    (rd_re_q),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	assign din.ready       = (state_q == S_IDLE);
	assign dout.valid      = out_valid_q;
	assign dout.sample_out = out_q;
	assign cfg.ready       = 1'b1;

	// multiply unit is never restarted in the middle of a product
	a_mac_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mac_ctl_q.start |-> !mac_sts.busy)
		else $error("multiply started while busy");

	// the feedback write never lands on the word being read for this sample
	a_rd_wr_apart: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we_q |-> (ram_waddr_q != rd_addr_q))
		else $error("delay write hits read address");

	// a new result only appears out of the output step
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output step");

	// fill count never passes the memory depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we_q |-> (32'(fill_q) <= 32'(MAX_DELAY)))
		else $error("fill count beyond depth");

endmodule

`default_nettype wire

### verif/tb_flanger_delay_fx.sv
`timescale 1ns / 100ps
// testbench for flanger_delay_fx: corner and random samples over the din channel,
// register writes between phases, every result scored against a bit-accurate predictor
// depends on fdx_pkg, fdx_if and the flanger_delay_fx rtl

module tb_flanger_delay_fx;
	import fdx_pkg::*;

	localparam int SW          = SAMPLE_WIDTH_DEF;
	localparam int LINE_LEN    = MAX_DELAY_DEF;
	localparam int PTR_W       = $clog2(LINE_LEN);
	localparam int TBL_BITS    = SINE_TABLE_BITS_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 250;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN_TAIL  = 120;
	localparam int MAX_REPORTS = 10;

	typedef logic signed [SW-1:0] sample_t;

	// flanger predictor plus the queue of output samples still owed by the block
	class flanger_scoreboard;
		sample_t            line_mem [LINE_LEN];
		logic [PTR_W-1:0]   wr_ptr;
		logic [31:0]        lfo_acc;
		sample_t            prev_wet;
		logic [30:0]        step_reg;
		logic [9:0]         depth_reg;
		logic signed [15:0] gain_reg;
		logic [15:0]        mix_reg;
		sample_t            expected_out [$];
		int                 n_checked;
		int                 n_errors;

		function new();
			foreach (line_mem[i]) line_mem[i] = '0;
			wr_ptr    = '0;
			lfo_acc   = '0;
			prev_wet  = '0;
			step_reg  = PHASE_STEP_RST;
			depth_reg = DEPTH_RST;
			gain_reg  = FB_GAIN_RST;
			mix_reg   = MIX_RST;
			n_checked = 0;
			n_errors  = 0;
		endfunction

		// q15 product rounding, floor of (p + half) / 2^15
		function longint round_q15(longint p);
			return (p + 64'sd16384) >>> 15;
		endfunction

		function longint clamp_sample(longint v);
			longint hi;
			hi = (longint'(1) <<< (SW - 1)) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		// sine table entry from a polynomial over the folded quarter wave
		function longint lfo_level(logic [TBL_BITS-1:0] idx);
			longint qsize, r, u, x, x2, x3, x5, s;
			qsize = longint'(1) <<< (TBL_BITS - 2);
			r     = longint'(idx[TBL_BITS-3:0]);
			u     = idx[TBL_BITS-2] ? qsize - r : r;
			x     = u <<< (17 - TBL_BITS);
			x2    = round_q15(x * x);
			x3    = round_q15(x2 * x);
			x5    = round_q15(x3 * x2);
			s     = round_q15(64'sd51472 * x - 64'sd21167 * x3 + 64'sd2611 * x5);
			if (s < 0) s = 0;
			if (s > 32767) s = 32767;
			return idx[TBL_BITS-1] ? -s : s;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PHASE_STEP: step_reg  = data[30:0];
				REG_DEPTH:      depth_reg = data[9:0];
				REG_FB_GAIN:    gain_reg  = data[15:0];
				REG_MIX:        mix_reg   = data[15:0];
				default: ;
			endcase
		endfunction

		// one accepted input sample: read tap, write feedback, mix, step the lfo
		function void note_sample(sample_t s);
			longint           xs, gain, mix, lfo01, dly, wet, fed, y;
			logic [PTR_W-1:0] rd;
			xs   = longint'(s);
			gain = longint'(gain_reg);
			if (gain > longint'(FB_LIMIT)) gain = longint'(FB_LIMIT);
			if (gain < -longint'(FB_LIMIT)) gain = -longint'(FB_LIMIT);
			mix   = (mix_reg > MIX_ONE) ? longint'(MIX_ONE) : longint'(mix_reg);
			lfo01 = (lfo_level(lfo_acc[31 -: TBL_BITS]) + 32768) >>> 1;
			dly   = (lfo01 * longint'(depth_reg)) >>> 15;
			if (dly < 1) dly = 1;
			if (dly > LINE_LEN - 1) dly = LINE_LEN - 1;
			rd  = wr_ptr - PTR_W'(dly);
			wet = longint'(line_mem[rd]);
			fed = clamp_sample(xs + round_q15(longint'(prev_wet) * gain));
			line_mem[wr_ptr] = sample_t'(fed);
			wr_ptr   = wr_ptr + 1'b1;
			prev_wet = sample_t'(wet);
			y = clamp_sample(round_q15(xs * (longint'(MIX_ONE) - mix) + wet * mix));
			expected_out.push_back(sample_t'(y));
			lfo_acc = lfo_acc + {1'b0, step_reg};
		endfunction

		function void check_result(sample_t got);
			sample_t want;
			if (expected_out.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("error: result %0d arrived with nothing pending", got);
				return;
			end
			want = expected_out.pop_front();
			n_checked++;
			if (got !== want) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("mismatch on result %0d: expected %0d, got %0d",
						n_checked, want, got);
			end
		endfunction
	endclass

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	flanger_scoreboard sb;
	int                send_idle_pct;
	int                stall_pct;
	int                hold_req;
	int                hold_seen = 0;
	int                hold_left = 0;
	int                n_sent;
	int                n_settings;

	fdx_in_if  #(.W(SW)) din_if ();
	fdx_out_if #(.W(SW)) dout_if ();
	fdx_cfg_if           cfg_if ();

	flanger_delay_fx u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	always #1 clk = ~clk;

	// output side: score each transfer, then pick ready for the next edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (dout_if.valid && dout_if.ready)
				sb.check_result(dout_if.sample_out);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// offer one sample, with random idle cycles ahead of it
	task automatic push_sample(input sample_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid     <= 1'b1;
		din_if.sample_in <= s;
		@(posedge clk);
		while (!din_if.ready) @(posedge clk);
		sb.note_sample(s);
		n_sent++;
	endtask

	// stop offering and wait until every owed result has come out
	task automatic wait_drained();
		din_if.valid <= 1'b0;
		do @(posedge clk); while (sb.expected_out.size() != 0);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// full register set, preceded by a write to an unmapped index
	task automatic apply_setting(input logic [31:0] step_v, depth_v, gain_v, mix_v);
		cfg_write(REG_UNUSED, $urandom);
		cfg_write(REG_PHASE_STEP, step_v);
		cfg_write(REG_DEPTH, depth_v);
		cfg_write(REG_FB_GAIN, gain_v);
		cfg_write(REG_MIX, mix_v);
		cfg_if.valid <= 1'b0;
		n_settings++;
	endtask

	initial begin
		sample_t     corners [8];
		int          p, k;
		logic [31:0] st_v, dp_v, gn_v, mx_v;
		sample_t     s;

		din_if.valid     = 1'b0;
		din_if.sample_in = '0;
		dout_if.ready    = 1'b0;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = '0;
		cfg_if.data      = '0;
		send_idle_pct    = 0;
		stall_pct        = 0;
		hold_req         = 0;
		n_sent           = 0;
		n_settings       = 0;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values with corner samples
		corners = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'shFFFF,
			16'sh0001, 16'sh5555, 16'shAAAA, 16'sh7FFF};
		foreach (corners[i]) push_sample(corners[i]);
		wait_drained();

		// still lfo, zero depth, gain and mix above their limits, feedback saturation
		apply_setting(32'h0000_0000, 32'h0000_0000, 32'h0000_7FFF, 32'h0000_FFFF);
		repeat (3) push_sample(16'sh7FFF);
		repeat (3) push_sample(16'sh8000);
		wait_drained();

		// top bits of data ignored, largest step and depth, gain below its limit, dry only
		apply_setting(32'hFFFF_FFFF, 32'h0000_03FF, 32'hFFFF_8000, 32'h0000_0000);
		foreach (corners[i]) push_sample(corners[i]);
		wait_drained();

		// random phases under changing registers and handshake pressure
		for (p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin
					st_v = 32'd1;
					dp_v = 32'd1023;
					gn_v = 32'(FB_LIMIT);
					mx_v = 32'(MIX_ONE);
				end
				1: begin
					st_v = 32'h7FFF_FFFF;
					dp_v = 32'd1;
					gn_v = 32'(-FB_LIMIT);
					mx_v = 32'd0;
				end
				default: begin
					st_v = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200000) : $urandom;
					dp_v = $urandom;
					gn_v = $urandom;
					mx_v = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32768);
				end
			endcase
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 60; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 60; end
				default: begin send_idle_pct = 38; stall_pct = 38; end
			endcase
			apply_setting(st_v, dp_v, gn_v, mx_v);
			// long output hold while samples keep coming, so din backs up
			if (p == 0) hold_req++;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 2 && k == PHASE_ITEMS / 2) wait_drained();
				case ($urandom_range(0, 9))
					0: s = 16'sh7FFF;
					1: s = 16'sh8000;
					default: s = sample_t'($urandom);
				endcase
				push_sample(s);
			end
			wait_drained();
		end

		// quiet tail so a stray late result gets caught
		repeat (DRAIN_TAIL) @(posedge clk);
		$display("run: %0d samples, %0d register settings, %0d results checked, %0d errors",
			n_sent, n_settings, sb.n_checked, sb.n_errors);
		$display("run: corner samples, clamped gain and mix, zero depth and step, stalls, gaps");
		if (sb.n_errors == 0 && sb.expected_out.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("timeout with %0d results still pending", sb.expected_out.size());
		$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
src/fdx_pkg.sv
src/fdx_if.sv
src/fdx_ram.sv
src/fdx_smac.sv
src/flanger_delay_fx.sv
verif/tb_flanger_delay_fx.sv
